// ===== rtl/core/stid_pkg.sv =====
// Shared types and constants for the sorted table with duplicate rejection.
`default_nettype none

package stid_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned NAME_W    = 32;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic shift;
    logic put;
    logic capture;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            cnt_zero;
    logic            scan_done;
    logic            dup;
    logic            slot_end;
    logic            shift_done;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/stid_dp.sv =====
// Datapath: entry memory, scan and shift pointers, count and result registers.
`default_nettype none

module stid_dp
  import stid_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic [NAME_W-1:0]    name_key_i,
  input  wire logic [SCORE_W-1:0]   score_i,
  input  wire logic [IDX_W-1:0]     index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [POS_W-1:0]          position_o,
  output logic [CNT_OUT_W-1:0]      entry_count_o,
  output logic [NAME_W-1:0]         key_out_o,
  output logic [SCORE_W-1:0]        score_out_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned KW   = (KEY_WIDTH < NAME_W) ? KEY_WIDTH : NAME_W;
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [KW-1:0]      key_mem   [DEPTH];
  logic [SCORE_W-1:0] score_mem [DEPTH];

  logic [OP_W-1:0]    op_q, op_d;
  logic [KW-1:0]      key_q, key_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      slot_q, slot_d;
  logic               cmp_v_q, cmp_v_d;
  logic [AW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               dup_q, dup_d;
  logic               found_q, found_d;
  logic               wv_q, wv_d;
  logic [AW-1:0]      widx_q, widx_d;
  logic [KW-1:0]      rkey_q;
  logic [SCORE_W-1:0] rscore_q;
  status_e            res_status_q, res_status_d;
  logic [AW-1:0]      res_pos_q, res_pos_d;
  logic [KW-1:0]      res_key_q, res_key_d;
  logic [SCORE_W-1:0] res_score_q, res_score_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;
  logic [NAME_W-1:0]  out_key_q, out_key_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [KW-1:0]      mem_wkey;
  logic [SCORE_W-1:0] mem_wscore;
  logic [AW-1:0]      rd_addr;
  logic               rd_ok;
  logic [CW-1:0]      ptr_m1;

  assign rd_ok  = (index_i != '0) && (CMPW'(index_i) <= CMPW'(cnt_q));
  assign ptr_m1 = ptr_q - CW'(1);

  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    score_d      = score_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    slot_d       = slot_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    dup_d        = dup_q;
    found_d      = found_q;
    wv_d         = wv_q;
    widx_d       = widx_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    res_score_d  = res_score_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_cnt_d    = out_cnt_q;
    out_key_d    = out_key_q;
    out_score_d  = out_score_q;
    mem_we       = 1'b0;
    mem_wa       = widx_q;
    mem_wkey     = rkey_q;
    mem_wscore   = rscore_q;
    rd_addr      = AW'(idx_q - IDX_W'(1));

    if (cmd_i.load) begin
      op_d        = op_i;
      key_d       = KW'(name_key_i);
      score_d     = score_i;
      idx_d       = index_i;
      ptr_d       = '0;
      slot_d      = cnt_q;
      cmp_v_d     = 1'b0;
      dup_d       = 1'b0;
      found_d     = 1'b0;
      wv_d        = 1'b0;
      res_pos_d   = '0;
      res_key_d   = '0;
      res_score_d = '0;
      case (op_i)
        OP_INSERT: res_status_d = (cnt_q == CW'(DEPTH)) ? ST_FULL : ST_DONE;
        OP_READ: begin
          res_status_d = rd_ok ? ST_DONE : ST_RANGE;
          if (rd_ok) begin
            res_pos_d = AW'(index_i - IDX_W'(1));
          end
        end
        default:   res_status_d = ST_DONE;
      endcase
    end

    if (cmd_i.clear) begin
      cnt_d = '0;
    end

    // Scan: the read of an entry is issued ahead of its compare, which works on the registered read data.
    if (cmd_i.scan) begin
      rd_addr = ptr_q[AW-1:0];
      if (ptr_q < cnt_q) begin
        ptr_d     = ptr_q + CW'(1);
        cmp_v_d   = 1'b1;
        cmp_idx_d = ptr_q[AW-1:0];
      end else begin
        cmp_v_d = 1'b0;
      end
      if (cmp_v_q) begin
        if (rkey_q == key_q) begin
          dup_d        = 1'b1;
          res_status_d = ST_DUP;
        end
        if (!found_q && (score_q <= rscore_q)) begin
          found_d = 1'b1;
          slot_d  = CW'(cmp_idx_q);
        end
      end
    end

    // Shift: read slot i-1, then write the registered read data to slot i.
    if (cmd_i.shift) begin
      rd_addr = AW'(ptr_m1);
      if (ptr_q > slot_q) begin
        ptr_d  = ptr_m1;
        wv_d   = 1'b1;
        widx_d = ptr_q[AW-1:0];
      end else begin
        wv_d = 1'b0;
      end
      if (wv_q) begin
        mem_we = 1'b1;
      end
    end

    if (cmd_i.put) begin
      mem_we     = 1'b1;
      mem_wa     = slot_q[AW-1:0];
      mem_wkey   = key_q;
      mem_wscore = score_q;
      cnt_d      = cnt_q + CW'(1);
      res_pos_d  = slot_q[AW-1:0];
    end

    if (cmd_i.capture) begin
      res_key_d   = rkey_q;
      res_score_d = rscore_q;
    end

    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_pos_d    = POS_W'(res_pos_q);
      out_cnt_d    = CNT_OUT_W'(cnt_q);
      out_key_d    = NAME_W'(res_key_q);
      out_score_d  = res_score_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_v_q     <= 1'b0;
      wv_q        <= 1'b0;
      dup_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      cmp_v_q     <= cmp_v_d;
      wv_q        <= wv_d;
      dup_q       <= dup_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    score_q      <= score_d;
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    slot_q       <= slot_d;
    cmp_idx_q    <= cmp_idx_d;
    widx_q       <= widx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    res_score_q  <= res_score_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_cnt_q    <= out_cnt_d;
    out_key_q    <= out_key_d;
    out_score_q  <= out_score_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa]   <= mem_wkey;
      score_mem[mem_wa] <= mem_wscore;
    end
    rkey_q   <= key_mem[rd_addr];
    rscore_q <= score_mem[rd_addr];
  end

  assign stat_o.op         = op_q;
  assign stat_o.ok         = (res_status_q == ST_DONE);
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.scan_done  = (ptr_q == cnt_q) && !cmp_v_q;
  assign stat_o.dup        = dup_q;
  assign stat_o.slot_end   = (slot_q == cnt_q);
  assign stat_o.shift_done = (ptr_q == slot_q) && !wv_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_cnt_q;
  assign key_out_o     = out_key_q;
  assign score_out_o   = out_score_q;

endmodule

`default_nettype wire

// ===== rtl/core/stid_ctrl.sv =====
// Controller: sequences load, clear, scan, shift, store, read capture and result hand-off.
`default_nettype none

module stid_ctrl
  import stid_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output dp_cmd_t       cmd_o,
  input  wire dp_stat_t stat_i
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SHIFT    = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_RDWAIT   = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.op == OP_INSERT && stat_i.ok) begin
          state_d = stat_i.cnt_zero ? S_PUT : S_SCAN;
        end else if (stat_i.op == OP_READ && stat_i.ok) begin
          state_d = S_RDWAIT;
        end else begin
          cmd_o.clear = (stat_i.op == OP_CLEAR);
          state_d     = S_OUT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.dup) begin
            state_d = S_OUT;
          end else begin
            state_d = stat_i.slot_end ? S_PUT : S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_OUT;
      end
      S_RDWAIT: begin
        cmd_o.capture = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/sorted_table_insert_dedup.sv =====
// Sorted (key, score) table with duplicate rejection: top level.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one operation per beat:
//   insert (op 0), read at one-based index (op 1) or clear (op 2).
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   beat per operation, in order, from an output register.
//   One operation is in flight at a time; in_stall_o is high while it runs.
//   Clear, unused op, full table and bad read go straight to the result;
//   a read waits for the memory read, and an insert into an empty table
//   stores at once; any other insert scans every entry (a duplicate key
//   ends there) and runs a move-up pass when the new entry lands below the end.
//   The scan and the move-up pass run one entry per cycle through the
//   single read port and single write port of the entry memory.
//   A finished result waits in the output register while the receiver
//   stalls; the next operation is accepted meanwhile and finishes once
//   the register is free.
//   Reset empties the table and drops any pending result; the entry
//   memory needs no clearing pass.
`default_nettype none

module sorted_table_insert_dedup
  import stid_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic [NAME_W-1:0]    name_key_i,
  input  wire logic [SCORE_W-1:0]   score_i,
  input  wire logic [IDX_W-1:0]     index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [POS_W-1:0]          position_o,
  output logic [CNT_OUT_W-1:0]      entry_count_o,
  output logic [NAME_W-1:0]         key_out_o,
  output logic [SCORE_W-1:0]        score_out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  stid_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .name_key_i    (name_key_i),
    .score_i       (score_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o),
    .key_out_o     (key_out_o),
    .score_out_o   (score_out_o)
  );

endmodule

`default_nettype wire

// ===== bench/sorted_table_insert_dedup_tb.sv =====
// Self-checking bench for the sorted (key, score) table with duplicate rejection.
module sorted_table_insert_dedup_tb
  import stid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1330;
  localparam int TAIL_ITEMS   = 150;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 50;

  // op value that the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [NAME_W-1:0]  key;
    logic [SCORE_W-1:0] score;
    logic [IDX_W-1:0]   index;
    logic               drain;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] count;
    logic [NAME_W-1:0]    key;
    logic [SCORE_W-1:0]   score;
  } table_res_t;

  logic                 clk       = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op     = '0;
  logic [NAME_W-1:0]    in_key    = '0;
  logic [SCORE_W-1:0]   in_score  = '0;
  logic [IDX_W-1:0]     in_index  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [POS_W-1:0]     out_position;
  logic [CNT_OUT_W-1:0] out_count;
  logic [NAME_W-1:0]    out_key;
  logic [SCORE_W-1:0]   out_score;

  table_op_t  pending_ops[$];
  table_res_t expected_results[$];
  table_op_t  cur_op;

  // predicted table contents
  logic [NAME_W-1:0]  tbl_key[TABLE_DEPTH];
  logic [SCORE_W-1:0] tbl_score[TABLE_DEPTH];
  int                 tbl_count = 0;

  // keys the generator expects to be in the table, to aim reads and duplicates
  logic [NAME_W-1:0] gen_keys[$];

  int total_items    = 0;
  int items_accepted = 0;
  int results_done   = 0;
  int mismatches     = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int src_gap        = 0;
  int snk_gap        = 0;
  logic long_hold    = 1'b0;

  sorted_table_insert_dedup dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (in_op),
    .name_key_i    (in_key),
    .score_i       (in_score),
    .index_i       (in_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (out_status),
    .position_o    (out_position),
    .entry_count_o (out_count),
    .key_out_o     (out_key),
    .score_out_o   (out_score)
  );

  always #10 clk = ~clk;

  // Apply one operation to the predicted table and return its result.
  function automatic table_res_t table_apply(table_op_t t);
    table_res_t r;
    int         slot;
    bit         dup;
    r = '0;
    r.status = ST_DONE;
    case (t.op)
      OP_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dup = 1'b0;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == t.key) dup = 1'b1;
          if (dup) begin
            r.status = ST_DUP;
          end else begin
            // land ahead of any entry with an equal score
            slot = 0;
            while (slot < tbl_count && t.score > tbl_score[slot]) slot++;
            for (int i = tbl_count; i > slot; i--) begin
              tbl_key[i]   = tbl_key[i-1];
              tbl_score[i] = tbl_score[i-1];
            end
            tbl_key[slot]   = t.key;
            tbl_score[slot] = t.score;
            tbl_count++;
            r.position = POS_W'(slot);
          end
        end
      end
      OP_READ: begin
        if (t.index == 0 || t.index > tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          r.position = POS_W'(t.index - 1);
          r.key      = tbl_key[t.index - 1];
          r.score    = tbl_score[t.index - 1];
        end
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.count = CNT_OUT_W'(tbl_count);
    return r;
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] op, logic [NAME_W-1:0] key,
                                   logic [SCORE_W-1:0] score, logic [IDX_W-1:0] index,
                                   logic drain);
    table_op_t t;
    bit        known;
    t = '{op: op, key: key, score: score, index: index, drain: drain};
    pending_ops.push_back(t);
    if (op == OP_INSERT && gen_keys.size() < TABLE_DEPTH) begin
      known = 1'b0;
      foreach (gen_keys[i])
        if (gen_keys[i] == key) known = 1'b1;
      if (!known) gen_keys.push_back(key);
    end else if (op == OP_CLEAR) begin
      gen_keys.delete();
    end
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Driver: offer queued beats, hold while stalled, idle in bursts.
  always @(posedge clk) begin
    bit fire;
    bit quiet;
    fire  = in_valid && !in_stall;
    quiet = (items_accepted >= total_items - TAIL_ITEMS) || ((items_accepted / 80) % 4 == 1);
    if (rst_ni) begin
      if (fire) begin
        expected_results.push_back(table_apply(cur_op));
        items_accepted <= items_accepted + 1;
      end
      if (!(in_valid && !fire)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0].drain && results_done != items_accepted + fire) begin
          // pause until every outstanding result is back
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 12) begin
          src_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          in_op    <= cur_op.op;
          in_key   <= cur_op.key;
          in_score <= cur_op.score;
          in_index <= cur_op.index;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver stall: random bursts plus the long hold.
  always @(posedge clk) begin
    bit quiet;
    bit burst;
    quiet = (items_accepted >= total_items - TAIL_ITEMS) || ((results_done / 70) % 4 == 2);
    burst = 1'b0;
    if (rst_ni) begin
      if (snk_gap > 0) begin
        snk_gap--;
        burst = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 10) begin
        snk_gap = $urandom_range(0, 11);
        burst = 1'b1;
      end
      out_stall <= long_hold || burst;
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    table_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got status %0d count %0d",
                 $time, out_status, out_count);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("position", 32'(want.position), 32'(out_position));
        check_field("entry_count", 32'(want.count), 32'(out_count));
        check_field("key_out", 32'(want.key), 32'(out_key));
        check_field("score_out", 32'(want.score), 32'(out_score));
        status_seen[out_status]++;
        results_done <= results_done + 1;
      end
    end
  end

  // Hold off the receiver long enough that the block backs up its input.
  initial begin
    wait (results_done >= 400);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #30_000_000;
    $display("sorted_table_insert_dedup test failed");
    $finish;
  end

  initial begin
    int                 fill_goal;
    int                 pick;
    int                 cnt;
    int                 rand_items;
    logic [NAME_W-1:0]  k;
    logic [SCORE_W-1:0] s;
    logic [IDX_W-1:0]   idx;

    // directed: empty reads, extremes, equal scores, duplicates, clear
    queue_op(OP_READ, 32'h0, 16'h0, 7'd1, 1'b0);
    queue_op(OP_READ, '1, '1, 7'd0, 1'b0);
    queue_op(OP_INSERT, 32'h0, 16'h8000, 7'd0, 1'b0);
    queue_op(OP_INSERT, '1, '1, '1, 1'b0);
    queue_op(OP_INSERT, 32'h5, 16'h0, 7'd1, 1'b0);
    queue_op(OP_INSERT, 32'h6, 16'h8000, 7'd0, 1'b0);
    queue_op(OP_INSERT, 32'h0, 16'h1, 7'd0, 1'b0);
    queue_op(OP_INSERT, '1, 16'h0, 7'd0, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd1, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd2, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd3, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd4, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd5, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd64, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd127, 1'b0);
    queue_op(OP_UNUSED, '1, '1, '1, 1'b0);
    queue_op(OP_CLEAR, 32'h1234_5678, 16'hABCD, 7'd3, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd1, 1'b0);
    queue_op(OP_INSERT, 32'h0, '1, 7'd0, 1'b0);
    queue_op(OP_READ, 32'h0, 16'h0, 7'd1, 1'b0);

    // random: fill rounds toward a goal, the first one to a full table
    fill_goal  = TABLE_DEPTH;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      cnt  = gen_keys.size();
      k    = $urandom;
      s    = 16'($urandom);
      idx  = 7'($urandom);
      if (pick < 10 && (cnt >= fill_goal || pick == 0)) begin
        queue_op(OP_CLEAR, k, s, idx, rand_items == 0 || rand_items == 650);
        fill_goal = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : $urandom_range(1, 40);
        rand_items++;
      end else if (pick < 12) begin
        queue_op(OP_UNUSED, k, s, idx, rand_items == 0 || rand_items == 650);
        rand_items++;
      end else if (pick < 62) begin
        pick = $urandom_range(0, 99);
        if (pick < 15 && cnt > 0) k = gen_keys[$urandom_range(0, cnt - 1)];
        else if (pick < 20) k = $urandom_range(0, 1) ? '1 : '0;
        pick = $urandom_range(0, 99);
        if (pick < 35) s = 16'($urandom_range(0, 15));
        else if (pick < 45) s = $urandom_range(0, 1) ? '1 : '0;
        queue_op(OP_INSERT, k, s, idx, rand_items == 0 || rand_items == 650);
        rand_items++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && cnt > 0) idx = 7'($urandom_range(1, cnt));
        else if (pick < 85) idx = 7'($urandom_range(cnt + 1, 127));
        queue_op(OP_READ, k, s, idx, rand_items == 0 || rand_items == 650);
        rand_items++;
      end
    end
    total_items = pending_ops.size();

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;

    wait (items_accepted == total_items && results_done == total_items);
    repeat (200) @(posedge clk);
    $display("Covered %0d operations: %0d completed, %0d duplicate keys, %0d full-table inserts,",
             total_items, status_seen[ST_DONE], status_seen[ST_DUP], status_seen[ST_FULL]);
    $display("and %0d out-of-range reads, with random stalls and a long output hold.",
             status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("sorted_table_insert_dedup test passed");
    end else begin
      $display("sorted_table_insert_dedup test failed");
    end
    $finish;
  end

endmodule

// ===== sorted_table_insert_dedup.f =====
rtl/core/stid_pkg.sv
rtl/core/stid_dp.sv
rtl/core/stid_ctrl.sv
rtl/core/sorted_table_insert_dedup.sv
bench/sorted_table_insert_dedup_tb.sv
